@@ rtl/spiq_pkg.sv @@
// ----------------------------------------------------------------------------
// spiq_pkg
// Shared types and constants for the sorted insertion priority queue.
// ----------------------------------------------------------------------------
package spiq_pkg;

   localparam int DEPTH     = 1024;
   localparam int TAG_BITS  = 16;
   localparam int PRIO_BITS = 3;
   localparam int IDX_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);
   localparam logic [IDX_BITS-1:0] LAST_INDEX = IDX_BITS'(DEPTH - 1);

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef struct packed {
      logic                 kind;
      logic [TAG_BITS-1:0]  entry_tag;
      logic [PRIO_BITS-1:0] entry_priority;
   } req_word_type;

   typedef struct packed {
      logic                 accepted;
      logic                 full_dropped;
      logic                 empty_seen;
      logic [TAG_BITS-1:0]  out_tag;
      logic [PRIO_BITS-1:0] out_priority;
      logic [IDX_BITS-1:0]  moved_count;
      logic [CNT_BITS-1:0]  occupancy;
   } rsp_word_type;

   typedef struct packed {
      logic [TAG_BITS-1:0]  tag;
      logic [PRIO_BITS-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_addr;
      entry_type           wr_data;
      logic                rd_en;
      logic [IDX_BITS-1:0] rd_addr;
   } mem_req_type;

endpackage

@@ rtl/spiq_store.sv @@
// ----------------------------------------------------------------------------
// spiq_store
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spiq_store (
   input  logic                 clock,
   input  spiq_pkg::mem_req_type mem_req,
   output spiq_pkg::entry_type   rd_data
);
   import spiq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/spiq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spiq_ctrl
// Sequencer: ring pointers, the backward shift walk and the result word.
// ----------------------------------------------------------------------------
module spiq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  spiq_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output spiq_pkg::rsp_word_type rsp_word,
   output spiq_pkg::mem_req_type  mem_req,
   input  spiq_pkg::entry_type    rd_data
);
   import spiq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_PLACE,
      ST_POP
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_BITS-1:0] head_ff, head_in;
   logic [IDX_BITS-1:0] tail_ff, tail_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [IDX_BITS-1:0] cur_ff, cur_in;
   logic [IDX_BITS-1:0] pos_ff, pos_in;
   logic [IDX_BITS-1:0] step_ff, step_in;
   entry_type           new_ff, new_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type        rsp_word_ff, rsp_word_in;
   logic [CNT_BITS-1:0] step_next;

   function automatic logic [IDX_BITS-1:0] wrap_prev(input logic [IDX_BITS-1:0] i);
      return (i == '0) ? LAST_INDEX : i - 1'b1;
   endfunction

   function automatic logic [IDX_BITS-1:0] wrap_next(input logic [IDX_BITS-1:0] i);
      return (i == LAST_INDEX) ? '0 : i + 1'b1;
   endfunction

   assign step_next = CNT_BITS'(step_ff) + 1'b1;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      new_in        = new_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      mem_req       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_word.kind == KIND_INSERT) begin
                  if (count_ff == FULL_COUNT) begin
                     rsp_strobe_in            = 1'b1;
                     rsp_word_in              = '0;
                     rsp_word_in.full_dropped = 1'b1;
                     rsp_word_in.occupancy    = count_ff;
                  end else if (count_ff == '0) begin
                     // nothing to pass, entry lands at the tail
                     mem_req.wr_en            = 1'b1;
                     mem_req.wr_addr          = tail_ff;
                     mem_req.wr_data.tag      = req_word.entry_tag;
                     mem_req.wr_data.prio     = req_word.entry_priority;
                     tail_in                  = wrap_next(tail_ff);
                     count_in                 = count_ff + 1'b1;
                     rsp_strobe_in            = 1'b1;
                     rsp_word_in              = '0;
                     rsp_word_in.accepted     = 1'b1;
                     rsp_word_in.occupancy    = count_ff + 1'b1;
                  end else begin
                     new_in.tag      = req_word.entry_tag;
                     new_in.prio     = req_word.entry_priority;
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = wrap_prev(tail_ff);
                     cur_in          = wrap_prev(tail_ff);
                     pos_in          = tail_ff;
                     step_in         = '0;
                     state_in        = ST_WALK;
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_strobe_in          = 1'b1;
                     rsp_word_in            = '0;
                     rsp_word_in.empty_seen = 1'b1;
                  end else begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = head_ff;
                     state_in        = ST_POP;
                  end
               end
            end
         end

         ST_WALK: begin
            if (rd_data.prio > new_ff.prio) begin
               // shift one slot toward the tail, prefetch the next older entry if any remain
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pos_ff;
               mem_req.wr_data = rd_data;
               pos_in          = cur_ff;
               step_in         = step_ff + 1'b1;
               if (step_next == count_ff) begin
                  state_in = ST_PLACE;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = wrap_prev(cur_ff);
                  cur_in          = wrap_prev(cur_ff);
               end
            end else begin
               mem_req.wr_en           = 1'b1;
               mem_req.wr_addr         = pos_ff;
               mem_req.wr_data         = new_ff;
               tail_in                 = wrap_next(tail_ff);
               count_in                = count_ff + 1'b1;
               rsp_strobe_in           = 1'b1;
               rsp_word_in             = '0;
               rsp_word_in.accepted    = 1'b1;
               rsp_word_in.moved_count = step_ff;
               rsp_word_in.occupancy   = count_ff + 1'b1;
               state_in                = ST_IDLE;
            end
         end

         ST_PLACE: begin
            mem_req.wr_en           = 1'b1;
            mem_req.wr_addr         = pos_ff;
            mem_req.wr_data         = new_ff;
            tail_in                 = wrap_next(tail_ff);
            count_in                = count_ff + 1'b1;
            rsp_strobe_in           = 1'b1;
            rsp_word_in             = '0;
            rsp_word_in.accepted    = 1'b1;
            rsp_word_in.moved_count = step_ff;
            rsp_word_in.occupancy   = count_ff + 1'b1;
            state_in                = ST_IDLE;
         end

         ST_POP: begin
            head_in                  = wrap_next(head_ff);
            count_in                 = count_ff - 1'b1;
            rsp_strobe_in            = 1'b1;
            rsp_word_in              = '0;
            rsp_word_in.accepted     = 1'b1;
            rsp_word_in.out_tag      = rd_data.tag;
            rsp_word_in.out_priority = rd_data.prio;
            rsp_word_in.occupancy    = count_ff - 1'b1;
            state_in                 = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cur_ff      <= cur_in;
      pos_ff      <= pos_in;
      step_ff     <= step_in;
      new_ff      <= new_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

@@ rtl/stable_priority_insert_queue_top.sv @@
// ----------------------------------------------------------------------------
// stable_priority_insert_queue_top
// Priority queue kept sorted in a ring buffer, stable among equal priorities.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A remove reads the
// head entry from the store and completes in ST_POP. An insert into a
// non-empty queue that is not full walks back from the tail in ST_WALK,
// ending in ST_PLACE when every held entry moves: the shift walk handles
// one entry per cycle through the single read and single write port of the
// entry store. An insert into an empty queue, a dropped insert and an empty
// remove finish in the cycle they are taken. The result word appears on
// rsp_word with rsp_strobe for exactly one cycle, the cycle after the item
// completes; the receiver cannot stall it, and a new word may be started in
// that same cycle. The store needs no clearing after reset.
module stable_priority_insert_queue_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  spiq_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output spiq_pkg::rsp_word_type rsp_word
);
   import spiq_pkg::*;

   mem_req_type mem_req;
   entry_type   rd_data;

   spiq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .mem_req    (mem_req),
      .rd_data    (rd_data)
   );

   spiq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // every result carries exactly one outcome
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $onehot({rsp_word.accepted, rsp_word.full_dropped,
                              rsp_word.empty_seen}))
      else $error("result word without a single outcome");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.full_dropped |-> rsp_word.occupancy == FULL_COUNT)
      else $error("insert dropped while store not full");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.empty_seen |-> rsp_word.occupancy == '0)
      else $error("empty remove with entries held");

   // the prefetch never hits the slot being shifted into
   assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en && mem_req.rd_en |-> mem_req.wr_addr != mem_req.rd_addr)
      else $error("store read and write collide");

endmodule
